[rtl/core/zone_write_pointer_manager_defines.svh]
// ----------------------------------------------------------------------------
// Zone write pointer manager assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ZONE_WRITE_POINTER_MANAGER_DEFINES_SVH
`define ZONE_WRITE_POINTER_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on the rising edge, disabled while reset is held
`define ZWPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check a property on the rising edge, also while reset is held
`define ZWPM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZWPM_ASSERT(lbl, clk, rstn, prop, msg)
`define ZWPM_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/zwpm_pkg.sv]
// ----------------------------------------------------------------------------
// Zone write pointer manager package
// Shared widths, codes, state encoding and the result record.
// ----------------------------------------------------------------------------
package zwpm_pkg;

    localparam int ZONES_DEF       = 64;
    localparam int OFFSET_BITS_DEF = 40;

    localparam int REQ_W      = 4;
    localparam int IDX_W      = 10;
    localparam int AMT_W      = 40;
    localparam int CNT_W      = 11;
    localparam int PCT_W      = 7;
    localparam int SUM_W      = 64;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int PCT_BASE   = 100;

    localparam logic [CNT_W-1:0] ACTIVE_LIMIT_RST = 11'd64;
    localparam logic [CNT_W-1:0] OPEN_LIMIT_RST   = 11'd64;
    localparam logic [AMT_W-1:0] ZONE_SIZE_RST    = 40'd268435456;

    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_PCT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SIZE    = 2'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD       = 4'd0,
        REQ_APPEND     = 4'd1,
        REQ_RESET      = 4'd2,
        REQ_FINISH     = 4'd3,
        REQ_SWEEP      = 4'd4,
        REQ_CHEAPEST   = 4'd5,
        REQ_TAKE_ACT   = 4'd6,
        REQ_RET_ACT    = 4'd7,
        REQ_TAKE_OPEN  = 4'd8,
        REQ_RET_OPEN   = 4'd9,
        REQ_SET_USED   = 4'd10,
        REQ_SPACE      = 4'd11
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_SPACE    = 2'd1,
        STAT_NOT_GRANTED = 2'd2,
        STAT_NO_FINISH   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_CHEAP,
        S_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    chosen;
        logic [AMT_W-1:0]    cap_left;
        logic [AMT_W-1:0]    wr_off;
        logic [CNT_W-1:0]    fin;
        logic [SUM_W-1:0]    free_sp;
        logic [SUM_W-1:0]    used_sp;
        logic [SUM_W-1:0]    recl_sp;
        logic [CNT_W-1:0]    active;
        logic [CNT_W-1:0]    open_tok;
    } result_t;

endpackage

[rtl/core/zwpm_if.sv]
// ----------------------------------------------------------------------------
// Zone write pointer manager channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
interface zwpm_req_if;
    import zwpm_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] zone_index;
    logic [AMT_W-1:0] amount;
    logic [AMT_W-1:0] load_write_offset;
    logic             load_writable;
    logic             reset_offline;
    logic             prioritized;

    modport source (output valid, req_type, zone_index, amount, load_write_offset,
                    load_writable, reset_offline, prioritized, input ready);
    modport sink   (input valid, req_type, zone_index, amount, load_write_offset,
                    load_writable, reset_offline, prioritized, output ready);
endinterface

interface zwpm_rsp_if;
    import zwpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    chosen_zone;
    logic [AMT_W-1:0]    capacity_left;
    logic [AMT_W-1:0]    write_offset;
    logic [CNT_W-1:0]    finished_count;
    logic [SUM_W-1:0]    free_space;
    logic [SUM_W-1:0]    used_space;
    logic [SUM_W-1:0]    reclaimable_space;
    logic [CNT_W-1:0]    active_tokens;
    logic [CNT_W-1:0]    open_tokens;

    modport source (output valid, status, chosen_zone, capacity_left, write_offset,
                    finished_count, free_space, used_space, reclaimable_space,
                    active_tokens, open_tokens, input ready);
    modport sink   (input valid, status, chosen_zone, capacity_left, write_offset,
                    finished_count, free_space, used_space, reclaimable_space,
                    active_tokens, open_tokens, output ready);
endinterface

[rtl/core/zwpm_zone_mem.sv]
// ----------------------------------------------------------------------------
// Zone table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module zwpm_zone_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 224
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write a record
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read a record into a registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/zwpm_ctrl.sv]
// ----------------------------------------------------------------------------
// Zone write pointer manager control
// Sequencer, read-modify-write datapath, table scan and token counters.
// ----------------------------------------------------------------------------
`include "zone_write_pointer_manager_defines.svh"

module zwpm_ctrl #(
    parameter int ZONES       = zwpm_pkg::ZONES_DEF,
    parameter int OFFSET_BITS = zwpm_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [zwpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [zwpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    zwpm_req_if.sink                         req,
    zwpm_rsp_if.source                       rsp,
    output logic                             mem_we,
    output logic [$clog2(ZONES)-1:0]         mem_waddr,
    output logic [4*OFFSET_BITS+63:0]        mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(ZONES)-1:0]         mem_raddr,
    input  logic [4*OFFSET_BITS+63:0]        mem_rdata
);
    import zwpm_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(ZONES);
    localparam int CW = $clog2(ZONES + 1);
    localparam int AW = (OB < AMT_W) ? OB : AMT_W;
    localparam int PW = OB + PCT_W;
    localparam int LW = OB + 8;

    typedef struct packed {
        logic [31:0]   fcnt;
        logic [31:0]   rcnt;
        logic [OB-1:0] used;
        logic [OB-1:0] cap_max;
        logic [OB-1:0] cap;
        logic [OB-1:0] off;
    } rec_t;

    function automatic logic [AMT_W-1:0] out40(logic [OB-1:0] v);
        return AMT_W'(v[AW-1:0]);
    endfunction

    function automatic rec_t finish_rec(rec_t r, logic [OB-1:0] zs);
        rec_t f;
        f      = r;
        f.cap  = '0;
        f.off  = zs;
        f.fcnt = r.fcnt + 32'd1;
        return f;
    endfunction

    ctrl_state_t state_reg, state_next;

    logic [PCT_W-1:0] pct_reg;
    logic [CNT_W-1:0] alim_reg, olim_reg;
    logic [AMT_W-1:0] zsize_reg;

    logic [CNT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [SUM_W-1:0] total_reg, total_next;

    req_type_t        op_reg, op_next;
    logic [IDX_W-1:0] zi_reg, zi_next;
    logic [OB-1:0]    amt_reg, amt_next;
    logic [OB-1:0]    lwo_reg, lwo_next;
    logic             wr_reg, wr_next;
    logic             offl_reg, offl_next;

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [IW-1:0]    s1_addr_reg, s1_addr_next;
    logic             s2_valid_reg, s2_valid_next;
    logic [IW-1:0]    s2_addr_reg, s2_addr_next;
    rec_t             s2_rec_reg, s2_rec_next;
    logic [PW-1:0]    s2_prod_reg, s2_prod_next;
    logic [LW-1:0]    s2_lhs_reg, s2_lhs_next;

    logic [SUM_W-1:0] fsum_reg, fsum_next;
    logic [SUM_W-1:0] usum_reg, usum_next;
    logic [SUM_W-1:0] rsum_reg, rsum_next;
    logic [CNT_W-1:0] fin_reg, fin_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    best_addr_reg, best_addr_next;
    rec_t             best_rec_reg, best_rec_next;

    logic             rsp_valid_reg, rsp_valid_next;
    result_t          rsp_data_reg, rsp_data_next;
    result_t          hold_reg, hold_next;

    rec_t             rd_rec, wr_rec, cur;
    logic [OB-1:0]    zs_o;
    logic             acc, out_free, fin_valid, s2_partial;
    result_t          fin_res;
    req_type_t        in_op;
    logic [CNT_W:0]   need;

    assign rd_rec    = mem_rdata;
    assign mem_wdata = wr_rec;
    assign zs_o      = OB'(zsize_reg[AW-1:0]);
    assign in_op     = req_type_t'(req.req_type);
    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign s2_partial = (s2_rec_reg.off != '0) && (s2_rec_reg.cap != '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg   <= '0;
            alim_reg  <= ACTIVE_LIMIT_RST;
            olim_reg  <= OPEN_LIMIT_RST;
            zsize_reg <= ZONE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FINISH_PCT:   pct_reg   <= cfg_data[PCT_W-1:0];
                CFG_ACTIVE_LIMIT: alim_reg  <= cfg_data[CNT_W-1:0];
                CFG_OPEN_LIMIT:   olim_reg  <= cfg_data[CNT_W-1:0];
                CFG_ZONE_SIZE:    zsize_reg <= cfg_data[AMT_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        open_next      = open_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        zi_next        = zi_reg;
        amt_next       = amt_reg;
        lwo_next       = lwo_reg;
        wr_next        = wr_reg;
        offl_next      = offl_reg;
        cnt_next       = cnt_reg;
        s1_valid_next  = 1'b0;
        s1_addr_next   = s1_addr_reg;
        s2_valid_next  = 1'b0;
        s2_addr_next   = s2_addr_reg;
        s2_rec_next    = s2_rec_reg;
        s2_prod_next   = s2_prod_reg;
        s2_lhs_next    = s2_lhs_reg;
        fsum_next      = fsum_reg;
        usum_next      = usum_reg;
        rsum_next      = rsum_reg;
        fin_next       = fin_reg;
        found_next     = found_reg;
        best_addr_next = best_addr_reg;
        best_rec_next  = best_rec_reg;
        hold_next      = hold_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        wr_rec         = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        fin_valid      = 1'b0;
        fin_res        = '0;
        cur            = rd_rec;
        need           = '0;

        case (state_reg)
            // zero the table after reset
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[IW-1:0];
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg[IW-1:0] == IW'(ZONES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take a request and dispatch it
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next   = in_op;
                    zi_next   = req.zone_index;
                    amt_next  = OB'(req.amount[AW-1:0]);
                    lwo_next  = OB'(req.load_write_offset[AW-1:0]);
                    wr_next   = req.load_writable;
                    offl_next = req.reset_offline;
                    fin_res.status = STAT_OK;
                    case (in_op)
                        REQ_LOAD, REQ_APPEND, REQ_RESET, REQ_FINISH, REQ_SET_USED:
                        begin
                            fin_res.chosen = req.zone_index;
                            if (int'(req.zone_index) < ZONES)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = req.zone_index[IW-1:0];
                                state_next = S_MOD;
                            end
                            else
                            begin
                                fin_valid = 1'b1;
                            end
                        end
                        REQ_SWEEP, REQ_CHEAPEST, REQ_SPACE:
                        begin
                            if (in_op == REQ_SWEEP && pct_reg == '0)
                            begin
                                fin_valid = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                fsum_next  = '0;
                                usum_next  = '0;
                                rsum_next  = '0;
                                fin_next   = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_TAKE_ACT:
                        begin
                            fin_valid = 1'b1;
                            if (active_reg < alim_reg)
                                active_next = active_reg + CNT_W'(1);
                            else
                                fin_res.status = STAT_NOT_GRANTED;
                        end
                        REQ_RET_ACT:
                        begin
                            fin_valid = 1'b1;
                            if (active_reg != '0)
                                active_next = active_reg - CNT_W'(1);
                        end
                        REQ_TAKE_OPEN:
                        begin
                            fin_valid = 1'b1;
                            need = {1'b0, open_reg} + (req.prioritized ? 12'd0 : 12'd1);
                            if (need < {1'b0, olim_reg})
                                open_next = open_reg + CNT_W'(1);
                            else
                                fin_res.status = STAT_NOT_GRANTED;
                        end
                        REQ_RET_OPEN:
                        begin
                            fin_valid = 1'b1;
                            if (open_reg != '0)
                                open_next = open_reg - CNT_W'(1);
                        end
                        default:
                        begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end

            // modify the addressed zone and write it back
            S_MOD:
            begin
                wr_rec = rd_rec;
                fin_res.status = STAT_OK;
                case (op_reg)
                    REQ_LOAD:
                    begin
                        wr_rec.off     = lwo_reg;
                        wr_rec.cap_max = amt_reg;
                        wr_rec.cap     = (wr_reg && lwo_reg <= amt_reg) ? amt_reg - lwo_reg
                                                                        : '0;
                        wr_rec.used    = '0;
                        wr_rec.rcnt    = '0;
                        wr_rec.fcnt    = '0;
                    end
                    REQ_APPEND:
                    begin
                        if (rd_rec.cap < amt_reg)
                        begin
                            fin_res.status = STAT_NO_SPACE;
                        end
                        else
                        begin
                            wr_rec.off = rd_rec.off + amt_reg;
                            wr_rec.cap = rd_rec.cap - amt_reg;
                            total_next = total_reg + SUM_W'(amt_reg);
                        end
                    end
                    REQ_RESET:
                    begin
                        if (offl_reg)
                        begin
                            wr_rec.cap = '0;
                        end
                        else
                        begin
                            wr_rec.cap_max = amt_reg;
                            wr_rec.cap     = amt_reg;
                        end
                        wr_rec.off  = '0;
                        wr_rec.rcnt = rd_rec.rcnt + 32'd1;
                    end
                    REQ_FINISH:
                    begin
                        wr_rec      = finish_rec(rd_rec, zs_o);
                        fin_res.fin = CNT_W'(1);
                    end
                    default:
                    begin
                        wr_rec.used = amt_reg;
                    end
                endcase
                mem_we           = 1'b1;
                mem_waddr        = zi_reg[IW-1:0];
                fin_valid        = 1'b1;
                fin_res.chosen   = zi_reg;
                fin_res.cap_left = out40(wr_rec.cap);
                fin_res.wr_off   = out40(wr_rec.off);
            end

            // walk the table: issue, register, evaluate
            S_SCAN:
            begin
                if (cnt_reg < CW'(ZONES))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg[IW-1:0];
                    cnt_next      = cnt_reg + CW'(1);
                    s1_valid_next = 1'b1;
                    s1_addr_next  = cnt_reg[IW-1:0];
                end
                s2_valid_next = s1_valid_reg;
                s2_addr_next  = s1_addr_reg;
                s2_rec_next   = rd_rec;
                s2_prod_next  = PW'(rd_rec.cap_max) * PW'(pct_reg);
                s2_lhs_next   = LW'(rd_rec.cap) * LW'(PCT_BASE) + LW'(PCT_BASE);

                if (s2_valid_reg)
                begin
                    case (op_reg)
                        REQ_SWEEP:
                        begin
                            if (s2_partial && s2_lhs_reg <= LW'(s2_prod_reg))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = s2_addr_reg;
                                wr_rec    = finish_rec(s2_rec_reg, zs_o);
                                fin_next  = fin_reg + CNT_W'(1);
                                if (active_reg != '0)
                                    active_next = active_reg - CNT_W'(1);
                            end
                        end
                        REQ_CHEAPEST:
                        begin
                            if (s2_partial && (!found_reg || s2_rec_reg.cap < best_rec_reg.cap))
                            begin
                                found_next     = 1'b1;
                                best_addr_next = s2_addr_reg;
                                best_rec_next  = s2_rec_reg;
                            end
                        end
                        default:
                        begin
                            fsum_next = fsum_reg + SUM_W'(s2_rec_reg.cap);
                            usum_next = usum_reg + SUM_W'(s2_rec_reg.used);
                            if (s2_rec_reg.cap == '0)
                                rsum_next = rsum_reg + SUM_W'(s2_rec_reg.cap_max)
                                                     - SUM_W'(s2_rec_reg.used);
                        end
                    endcase

                    // last entry evaluated
                    if (s2_addr_reg == IW'(ZONES - 1))
                    begin
                        if (op_reg == REQ_CHEAPEST)
                        begin
                            state_next = S_CHEAP;
                        end
                        else
                        begin
                            fin_valid       = 1'b1;
                            fin_res.status  = STAT_OK;
                            fin_res.fin     = fin_next;
                            if (op_reg == REQ_SPACE)
                            begin
                                fin_res.free_sp = fsum_next;
                                fin_res.used_sp = usum_next;
                                fin_res.recl_sp = rsum_next;
                            end
                        end
                    end
                end
            end

            // finish the cheapest partial zone
            S_CHEAP:
            begin
                fin_valid = 1'b1;
                if (found_reg)
                begin
                    cur              = finish_rec(best_rec_reg, zs_o);
                    wr_rec           = cur;
                    mem_we           = 1'b1;
                    mem_waddr        = best_addr_reg;
                    if (active_reg != '0)
                        active_next = active_reg - CNT_W'(1);
                    fin_res.status   = STAT_OK;
                    fin_res.fin      = CNT_W'(1);
                    fin_res.chosen   = IDX_W'(best_addr_reg);
                    fin_res.cap_left = out40(cur.cap);
                    fin_res.wr_off   = out40(cur.off);
                end
                else
                begin
                    fin_res.status = STAT_NO_FINISH;
                end
            end

            // wait for the output register to drain
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // token counters after the request
        fin_res.active   = active_next;
        fin_res.open_tok = open_next;

        // hand the result on, or park it
        if (fin_valid)
        begin
            if (out_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                hold_next  = fin_res;
                state_next = S_RESP;
            end
        end
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        if (fin_valid && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = fin_res;
        end
        else if (state_reg == S_RESP && out_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = hold_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            active_reg    <= '0;
            open_reg      <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            open_reg      <= open_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        zi_reg        <= zi_next;
        amt_reg       <= amt_next;
        lwo_reg       <= lwo_next;
        wr_reg        <= wr_next;
        offl_reg      <= offl_next;
        s1_addr_reg   <= s1_addr_next;
        s2_addr_reg   <= s2_addr_next;
        s2_rec_reg    <= s2_rec_next;
        s2_prod_reg   <= s2_prod_next;
        s2_lhs_reg    <= s2_lhs_next;
        fsum_reg      <= fsum_next;
        usum_reg      <= usum_next;
        rsum_reg      <= rsum_next;
        fin_reg       <= fin_next;
        best_addr_reg <= best_addr_next;
        best_rec_reg  <= best_rec_next;
        hold_reg      <= hold_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.status            = rsp_data_reg.status;
    assign rsp.chosen_zone       = rsp_data_reg.chosen;
    assign rsp.capacity_left     = rsp_data_reg.cap_left;
    assign rsp.write_offset      = rsp_data_reg.wr_off;
    assign rsp.finished_count    = rsp_data_reg.fin;
    assign rsp.free_space        = rsp_data_reg.free_sp;
    assign rsp.used_space        = rsp_data_reg.used_sp;
    assign rsp.reclaimable_space = rsp_data_reg.recl_sp;
    assign rsp.active_tokens     = rsp_data_reg.active;
    assign rsp.open_tokens       = rsp_data_reg.open_tok;

    `ZWPM_ASSERT(a_we_busy, clk, rst_n, mem_we |-> (state_reg != S_IDLE && state_reg != S_RESP), "table written while idle")
    `ZWPM_ASSERT(a_resp_full, clk, rst_n, (state_reg == S_RESP) |-> rsp_valid_reg, "parked result with empty output")
    `ZWPM_ASSERT(a_scan_only, clk, rst_n, s2_valid_reg |-> (state_reg == S_SCAN), "scan stage outside scan")
    `ZWPM_ASSERT(a_rmw_next, clk, rst_n, (acc && mem_re) |=> (state_reg == S_MOD), "read not followed by write-back")

endmodule

[rtl/core/zone_write_pointer_manager.sv]
// ----------------------------------------------------------------------------
// Zone write pointer manager
// Zone table with write pointers, capacities, token counters and sweeps.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+------------------------------------------------------
//  req     | in  | req_type, zone_index, amount, load fields, flags
//  rsp     | out | status, zone, capacity, offset, counts, sums, tokens
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Token requests and out-of-range zones are settled at accept; single-zone
// requests read the table at accept, then modify and write back on one port.
// Sweep, finish-cheapest and space query walk the table; finish-cheapest
// then writes back the zone that it chose in a further state.
// After reset a clearing pass zeros every table entry; no request
// is taken during it. A stalled result is parked; the next request waits.
module zone_write_pointer_manager #(
    parameter int ZONES       = zwpm_pkg::ZONES_DEF,
    parameter int OFFSET_BITS = zwpm_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [zwpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zwpm_pkg::CFG_DATA_W-1:0] cfg_data,
    zwpm_req_if.sink                        req,
    zwpm_rsp_if.source                      rsp
);
    import zwpm_pkg::*;

    localparam int IW    = $clog2(ZONES);
    localparam int REC_W = 4 * OFFSET_BITS + 64;

    logic             mem_we, mem_re;
    logic [IW-1:0]    mem_waddr, mem_raddr;
    logic [REC_W-1:0] mem_wdata, mem_rdata;

    // control and datapath
    zwpm_ctrl #(
        .ZONES       (ZONES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // zone table
    zwpm_zone_mem #(
        .DEPTH (ZONES),
        .WIDTH (REC_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[sim/tb_zone_write_pointer_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zone write pointer manager testbench
// Drives a directed table, then random requests over several register
// settings. Responses are checked against fixed values or an in-bench zone table model.
// ----------------------------------------------------------------------------
module tb_zone_write_pointer_manager;
    import zwpm_pkg::*;

    localparam int NZ = 64;
    localparam logic [AMT_W-1:0] AMAX = {AMT_W{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    zwpm_req_if req_ch ();
    zwpm_rsp_if rsp_ch ();

    zone_write_pointer_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // model of the zone table
    logic [AMT_W-1:0] m_off [NZ];
    logic [AMT_W-1:0] m_cap [NZ];
    logic [AMT_W-1:0] m_max [NZ];
    logic [AMT_W-1:0] m_used [NZ];
    logic [31:0] m_resets [NZ];
    logic [31:0] m_finishes [NZ];
    logic [CNT_W-1:0] m_active;
    logic [CNT_W-1:0] m_open;
    logic [63:0] m_written;
    logic [PCT_W-1:0] m_pct;
    logic [CNT_W-1:0] m_act_lim;
    logic [CNT_W-1:0] m_open_lim;
    logic [AMT_W-1:0] m_zsize;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [IDX_W-1:0] zone;
        logic [AMT_W-1:0] amt;
        logic [AMT_W-1:0] lwo;
        logic wr;
        logic offl;
        logic prio;
    } zreq_t;

    typedef struct {
        zreq_t r;
        bit fixed;
        result_t res;
    } row_t;

    result_t pending_rsp [$];
    int errors;
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [AMT_W-1:0] rnd40();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[AMT_W-1:0];
    endfunction

    task automatic model_reset();
        for (int z = 0; z < NZ; z++)
        begin
            m_off[z] = '0; m_cap[z] = '0; m_max[z] = '0; m_used[z] = '0;
            m_resets[z] = '0; m_finishes[z] = '0;
        end
        m_active = '0; m_open = '0; m_written = '0;
        m_pct = '0; m_act_lim = ACTIVE_LIMIT_RST; m_open_lim = OPEN_LIMIT_RST;
        m_zsize = ZONE_SIZE_RST;
    endtask

    function automatic bit partial(int z);
        return m_off[z] != '0 && m_cap[z] != '0;
    endfunction

    task automatic finish_zone(int z);
        m_cap[z] = '0;
        m_off[z] = m_zsize;
        m_finishes[z] += 1;
    endtask

    task automatic drop_active();
        if (m_active != '0) m_active -= 1;
    endtask

    // advance the model by one request and work out its response
    task automatic predict_zone_op(input zreq_t r, output result_t o);
        logic [63:0] lim;
        bit show;
        bit found;
        int shown;
        int best;
        int zi;
        o = '0;
        show = 0;
        shown = 0;
        zi = r.zone;
        case (r.kind)
            REQ_LOAD, REQ_APPEND, REQ_RESET, REQ_FINISH, REQ_SET_USED:
            begin
                o.chosen = r.zone;
                if (zi < NZ)
                begin
                    show = 1;
                    shown = zi;
                    case (r.kind)
                        REQ_LOAD:
                        begin
                            m_off[zi] = r.lwo;
                            m_max[zi] = r.amt;
                            m_cap[zi] = (r.wr && r.lwo <= r.amt) ? r.amt - r.lwo : '0;
                            m_used[zi] = '0;
                            m_resets[zi] = '0;
                            m_finishes[zi] = '0;
                        end
                        REQ_APPEND:
                        begin
                            if (m_cap[zi] < r.amt) o.status = STAT_NO_SPACE;
                            else
                            begin
                                m_off[zi] = m_off[zi] + r.amt;
                                m_cap[zi] = m_cap[zi] - r.amt;
                                m_written += 64'(r.amt);
                            end
                        end
                        REQ_RESET:
                        begin
                            if (r.offl) m_cap[zi] = '0;
                            else
                            begin
                                m_max[zi] = r.amt;
                                m_cap[zi] = r.amt;
                            end
                            m_off[zi] = '0;
                            m_resets[zi] += 1;
                        end
                        REQ_FINISH:
                        begin
                            finish_zone(zi);
                            o.fin = 1;
                        end
                        default: m_used[zi] = r.amt;
                    endcase
                end
            end
            REQ_SWEEP:
            begin
                if (m_pct != '0)
                begin
                    for (int z = 0; z < NZ; z++)
                    begin
                        lim = 64'(m_max[z]) * 64'(m_pct) / 64'(PCT_BASE);
                        if (partial(z) && 64'(m_cap[z]) < lim)
                        begin
                            finish_zone(z);
                            drop_active();
                            o.fin += 1;
                        end
                    end
                end
            end
            REQ_CHEAPEST:
            begin
                found = 0;
                best = 0;
                for (int z = 0; z < NZ; z++)
                    if (partial(z) && (!found || m_cap[z] < m_cap[best]))
                    begin
                        best = z;
                        found = 1;
                    end
                if (found)
                begin
                    finish_zone(best);
                    drop_active();
                    o.fin = 1;
                    o.chosen = best;
                    show = 1;
                    shown = best;
                end
                else o.status = STAT_NO_FINISH;
            end
            REQ_TAKE_ACT:
            begin
                if (m_active < m_act_lim) m_active += 1;
                else o.status = STAT_NOT_GRANTED;
            end
            REQ_RET_ACT: drop_active();
            REQ_TAKE_OPEN:
            begin
                if (m_open + (r.prio ? 0 : 1) < m_open_lim) m_open += 1;
                else o.status = STAT_NOT_GRANTED;
            end
            REQ_RET_OPEN:
            begin
                if (m_open != '0) m_open -= 1;
            end
            REQ_SPACE:
            begin
                for (int z = 0; z < NZ; z++)
                begin
                    o.free_sp += 64'(m_cap[z]);
                    o.used_sp += 64'(m_used[z]);
                    if (m_cap[z] == '0) o.recl_sp += 64'(m_max[z]) - 64'(m_used[z]);
                end
            end
            default: ;
        endcase
        if (show)
        begin
            o.cap_left = m_cap[shown];
            o.wr_off = m_off[shown];
        end
        o.active = m_active;
        o.open_tok = m_open;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_FINISH_PCT: m_pct = d[PCT_W-1:0];
            CFG_ACTIVE_LIMIT: m_act_lim = d[CNT_W-1:0];
            CFG_OPEN_LIMIT: m_open_lim = d[CNT_W-1:0];
            default: m_zsize = d;
        endcase
    endtask

    // hold until every response is back, then let the block settle
    task automatic drain();
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (NZ + 8) @(negedge clk);
    endtask

    // drive one request at the falling edge; hold until the transfer
    task automatic send(input zreq_t r, input bit fixed, input result_t fixed_res);
        result_t e;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = r.kind;
        req_ch.zone_index = r.zone;
        req_ch.amount = r.amt;
        req_ch.load_write_offset = r.lwo;
        req_ch.load_writable = r.wr;
        req_ch.reset_offline = r.offl;
        req_ch.prioritized = r.prio;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready) break;
        end
        predict_zone_op(r, e);
        pending_rsp = {pending_rsp, (fixed ? fixed_res : e)};
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    function automatic zreq_t mk(logic [REQ_W-1:0] k, logic [IDX_W-1:0] z,
                                 logic [AMT_W-1:0] a, logic [AMT_W-1:0] w,
                                 logic wr, logic offl, logic prio);
        zreq_t r;
        r.kind = k; r.zone = z; r.amt = a; r.lwo = w;
        r.wr = wr; r.offl = offl; r.prio = prio;
        return r;
    endfunction

    function automatic zreq_t random_req();
        zreq_t r;
        int p;
        int q;
        p = $urandom_range(0, 99);
        if (p < 15) r.kind = REQ_LOAD;
        else if (p < 40) r.kind = REQ_APPEND;
        else if (p < 48) r.kind = REQ_RESET;
        else if (p < 53) r.kind = REQ_FINISH;
        else if (p < 59) r.kind = REQ_SWEEP;
        else if (p < 65) r.kind = REQ_CHEAPEST;
        else if (p < 69) r.kind = REQ_TAKE_ACT;
        else if (p < 73) r.kind = REQ_RET_ACT;
        else if (p < 77) r.kind = REQ_TAKE_OPEN;
        else if (p < 81) r.kind = REQ_RET_OPEN;
        else if (p < 87) r.kind = REQ_SET_USED;
        else if (p < 97) r.kind = REQ_SPACE;
        else r.kind = REQ_W'($urandom_range(12, 15));
        q = $urandom_range(0, 99);
        if (q < 75) r.zone = $urandom_range(0, NZ - 1);
        else if (q < 92) r.zone = $urandom_range(0, 7);
        else r.zone = $urandom;
        q = $urandom_range(0, 99);
        if (q < 70) r.amt = $urandom_range(0, 4095);
        else if (q < 85) r.amt = rnd40();
        else r.amt = $urandom_range(0, 1) ? AMAX : '0;
        q = $urandom_range(0, 99);
        if (q < 75) r.lwo = $urandom_range(0, 1024);
        else if (q < 90) r.lwo = rnd40();
        else r.lwo = '0;
        r.wr = $urandom_range(0, 9) != 0;
        r.offl = $urandom_range(0, 7) == 0;
        r.prio = $urandom_range(0, 1);
        return r;
    endfunction

    // response side: random stalls, compare each transfer with the oldest entry
    initial
    begin
        int g;
        result_t e;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                @(posedge clk);
                if (rsp_ch.valid)
                begin
                    if (pending_rsp.size() == 0)
                    begin
                        $display("%0t response with nothing pending", $time);
                        errors++;
                    end
                    else
                    begin
                        e = pending_rsp.pop_front();
                        if (rsp_ch.status !== e.status)
                        begin
                            $display("%0t status exp %0d got %0d", $time, e.status, rsp_ch.status);
                            errors++;
                        end
                        if (rsp_ch.chosen_zone !== e.chosen)
                        begin
                            $display("%0t zone exp %0d got %0d", $time, e.chosen, rsp_ch.chosen_zone);
                            errors++;
                        end
                        if (rsp_ch.capacity_left !== e.cap_left)
                        begin
                            $display("%0t capacity exp %0h got %0h", $time, e.cap_left,
                                     rsp_ch.capacity_left);
                            errors++;
                        end
                        if (rsp_ch.write_offset !== e.wr_off)
                        begin
                            $display("%0t offset exp %0h got %0h", $time, e.wr_off,
                                     rsp_ch.write_offset);
                            errors++;
                        end
                        if (rsp_ch.finished_count !== e.fin)
                        begin
                            $display("%0t finished exp %0d got %0d", $time, e.fin,
                                     rsp_ch.finished_count);
                            errors++;
                        end
                        if (rsp_ch.free_space !== e.free_sp)
                        begin
                            $display("%0t free exp %0h got %0h", $time, e.free_sp, rsp_ch.free_space);
                            errors++;
                        end
                        if (rsp_ch.used_space !== e.used_sp)
                        begin
                            $display("%0t used exp %0h got %0h", $time, e.used_sp, rsp_ch.used_space);
                            errors++;
                        end
                        if (rsp_ch.reclaimable_space !== e.recl_sp)
                        begin
                            $display("%0t reclaimable exp %0h got %0h", $time, e.recl_sp,
                                     rsp_ch.reclaimable_space);
                            errors++;
                        end
                        if (rsp_ch.active_tokens !== e.active)
                        begin
                            $display("%0t active exp %0d got %0d", $time, e.active,
                                     rsp_ch.active_tokens);
                            errors++;
                        end
                        if (rsp_ch.open_tokens !== e.open_tok)
                        begin
                            $display("%0t open exp %0d got %0d", $time, e.open_tok,
                                     rsp_ch.open_tokens);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        row_t rows [$];
        row_t rw;
        result_t none;
        logic [CFG_DATA_W-1:0] pcts [4];
        logic [CFG_DATA_W-1:0] acts [4];
        logic [CFG_DATA_W-1:0] opens [4];
        logic [CFG_DATA_W-1:0] sizes [4];
        int wait_cycles;

        errors = 0;
        no_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_SPACE;
        req_ch.zone_index = '0;
        req_ch.amount = '0;
        req_ch.load_write_offset = '0;
        req_ch.load_writable = 1'b0;
        req_ch.reset_offline = 1'b0;
        req_ch.prioritized = 1'b0;
        model_reset();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed table; fixed rows carry their response
        none = '0;
        rw.fixed = 1; rw.res = none;
        rw.r = mk(REQ_SPACE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_RET_ACT, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_RET_OPEN, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(4'd12, 5, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(4'd15, 9, AMAX, AMAX, 1, 1, 1); rows = {rows, rw};
        rw.res = none; rw.res.chosen = 10'd1023;
        rw.r = mk(REQ_APPEND, 10'd1023, 5, 0, 0, 0, 0); rows = {rows, rw};
        rw.res = none; rw.res.status = STAT_NO_FINISH;
        rw.r = mk(REQ_CHEAPEST, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.res = none;
        rw.r = mk(REQ_SWEEP, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.fixed = 0;
        rw.r = mk(REQ_LOAD, 0, 1000, 0, 1, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_APPEND, 0, 400, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_APPEND, 0, 700, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_LOAD, 63, 10, 20, 1, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_LOAD, 1, 500, 5, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_RESET, 2, AMAX, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_APPEND, 2, AMAX, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_SET_USED, 2, AMAX, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_SET_USED, 0, 600, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_RESET, 0, 0, 0, 0, 1, 0); rows = {rows, rw};
        rw.r = mk(REQ_FINISH, 3, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_LOAD, 5, 1000, 10, 1, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_LOAD, 6, 500, 10, 1, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_TAKE_ACT, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_TAKE_OPEN, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_CHEAPEST, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        rw.r = mk(REQ_SPACE, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
        foreach (rows[i]) send(rows[i].r, rows[i].fixed, rows[i].res);

        // register settings per phase, extremes first
        pcts[0] = 50; acts[0] = 64; opens[0] = 64; sizes[0] = ZONE_SIZE_RST;
        pcts[1] = 100; acts[1] = 0; opens[1] = 0; sizes[1] = 1;
        pcts[2] = 0; acts[2] = 1024; opens[2] = 1024; sizes[2] = AMAX;
        pcts[3] = $urandom_range(1, 99); acts[3] = $urandom_range(1, 8);
        opens[3] = $urandom_range(1, 8); sizes[3] = rnd40();

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            cfg_write(CFG_FINISH_PCT, pcts[ph]);
            cfg_write(CFG_ACTIVE_LIMIT, acts[ph]);
            cfg_write(CFG_OPEN_LIMIT, opens[ph]);
            cfg_write(CFG_ZONE_SIZE, sizes[ph]);
            no_idle = (ph == 2);
            for (int n = 0; n < 190; n++)
            begin
                // hold the sender once until the pipeline is empty
                if (ph == 1 && n == 95)
                    while (pending_rsp.size() != 0) @(negedge clk);
                send(random_req(), 0, none);
            end
        end
        no_idle = 0;

        wait_cycles = 0;
        while (pending_rsp.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (NZ + 8) @(negedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/zwpm_pkg.sv
rtl/core/zwpm_if.sv
rtl/core/zwpm_zone_mem.sv
rtl/core/zwpm_ctrl.sv
rtl/core/zone_write_pointer_manager.sv
sim/tb_zone_write_pointer_manager.sv
